>>> rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants for the tile/sprite blitter
// Geometry, command codes, blend table and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package tsb_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned DimW = 9;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    CMD_PLOT = 2'd0, CMD_FILL = 2'd1, CMD_SPRITE = 2'd2, CMD_READ = 2'd3
  } cmd_e;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_SPRITE, ST_RDWAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;      // capture input beat
    logic clr_step;  // clearing pass write
    logic fill_step;
    logic spr_step;
    logic rd_issue;
    logic rd_capture;
    logic res_load;  // load result register
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic fill_done;
    logic fill_empty;
    logic spr_done;
  } sts_t;

  function automatic logic [1:0] blend(input logic [1:0] ch, input logic [3:0] c);
    logic [1:0] r;
    case (ch)
      2'd0: begin
        case (c)
          4'd4, 4'd6, 4'd7: r = 2'd1;
          4'd8, 4'd9, 4'd11: r = 2'd2;
          4'd12, 4'd13, 4'd14: r = 2'd3;
          default: r = 2'd0;
        endcase
      end
      2'd1: r = c[1:0];
      2'd2: r = (c[1:0] == 2'd3) ? 2'd1 : c[1:0] + 2'd1;
      default: r = (c[1:0] == 2'd1) ? 2'd3 : ((c[1:0] == 2'd2) ? 2'd1 : 2'd2);
    endcase
    return r;
  endfunction

  function automatic logic [DimW-1:0] clamp_w(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] mx);
    if (v < DimW'(8)) return DimW'(8);
    if (v > mx) return mx;
    return v;
  endfunction
endpackage
`default_nettype wire

>>> rtl/tsb_if.sv
// ----------------------------------------------------------------------------
// tsb_cmd_if / tsb_res_if: valid/ready channels
// Command and result channels of the blitter.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsb_cmd_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic layer_select;
  logic [3:0] color_code;
  logic flip_x;
  logic flip_y;
  logic two_bits;
  logic [63:0] plane_low;
  logic [63:0] plane_high;
  modport source (output valid, command, pos_x, pos_y, layer_select, color_code,
                  flip_x, flip_y, two_bits, plane_low, plane_high, input ready);
  modport sink (input valid, command, pos_x, pos_y, layer_select, color_code,
                flip_x, flip_y, two_bits, plane_low, plane_high, output ready);
endinterface

interface tsb_res_if;
  logic valid;
  logic ready;
  logic [1:0] read_color;
  logic in_bounds;
  modport source (output valid, read_color, in_bounds, input ready);
  modport sink (input valid, read_color, in_bounds, output ready);
endinterface
`default_nettype wire

>>> rtl/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// tsb_ctrl: command sequencer
// Clearing pass after reset, then one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module tsb_ctrl import tsb_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  cmd_e cmd_i,
  input  wire  res_busy_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output ctl_t ctl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i && !res_busy_i) begin
          case (cmd_i)
            CMD_FILL:   state_d = ST_FILL;
            CMD_SPRITE: state_d = ST_SPRITE;
            CMD_READ:   state_d = ST_RDWAIT;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_FILL: if (sts_i.fill_empty || sts_i.fill_done) state_d = ST_OUT;
      ST_SPRITE: if (sts_i.spr_done) state_d = ST_OUT;
      ST_RDWAIT: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: ctl_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = !res_busy_i;
        ctl_o.load = in_valid_i && !res_busy_i;
      end
      ST_FILL: ctl_o.fill_step = !sts_i.fill_empty;
      ST_SPRITE: ctl_o.spr_step = 1'b1;
      ST_RDWAIT: ctl_o.rd_capture = 1'b1;
      ST_OUT: ctl_o.res_load = 1'b1;
      default: ;
    endcase
    ctl_o.rd_issue = ctl_o.load;
  end
endmodule
`default_nettype wire

>>> rtl/tsb_dp.sv
// ----------------------------------------------------------------------------
// tsb_dp: blitter datapath
// Command registers, fill and sprite walkers, layer memory, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module tsb_dp import tsb_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  ctl_t ctl_i,
  output sts_t sts_o,
  input  wire  [1:0] cmd_i,
  input  wire  [15:0] px_i,
  input  wire  [15:0] py_i,
  input  wire  fg_i,
  input  wire  [3:0] color_i,
  input  wire  fx_i,
  input  wire  fy_i,
  input  wire  two_i,
  input  wire  [63:0] lo_i,
  input  wire  [63:0] hi_i,
  input  wire  cfg_we_i,
  input  wire  [CfgIdxW-1:0] cfg_idx_i,
  input  wire  [DimW-1:0] cfg_data_i,
  input  wire  res_ready_i,
  output logic res_valid_o,
  output logic [1:0] res_color_o,
  output logic res_ib_o
);
  logic [DimW-1:0] sw_q, sh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= clamp_w(DimW'(256), DimW'(MaxWidth));
      sh_q <= clamp_w(DimW'(256), DimW'(MaxHeight));
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WIDTH) sw_q <= clamp_w(cfg_data_i, DimW'(MaxWidth));
      else sh_q <= clamp_w(cfg_data_i, DimW'(MaxHeight));
    end
  end

  // captured command
  logic [1:0] cmd_q;
  logic [15:0] px_q, py_q;
  logic fg_q, fx_q, fy_q, two_q, onscr_q;
  logic [3:0] color_q;
  logic [63:0] lo_q, hi_q;
  logic onscr;
  assign onscr = ({1'b0, px_i} < 17'(sw_q)) && ({1'b0, py_i} < 17'(sh_q));

  // fill bounds
  logic [DimW-1:0] fx1_q, fx2_q, fy2_q, fxc_q, fyc_q;
  logic [DimW-1:0] x1c, x2c, y1c, y2c;
  always_comb begin
    logic [16:0] t;
    if (fx_i) begin x1c = '0; t = {1'b0, px_i}; end
    else begin
      x1c = ({1'b0, px_i} < 17'(sw_q)) ? px_i[DimW-1:0] : sw_q;
      t = 17'(sw_q);
    end
    x2c = (t > 17'(sw_q)) ? sw_q : t[DimW-1:0];
    if (fy_i) begin y1c = '0; t = {1'b0, py_i}; end
    else begin
      y1c = ({1'b0, py_i} < 17'(sh_q)) ? py_i[DimW-1:0] : sh_q;
      t = 17'(sh_q);
    end
    y2c = (t > 17'(sh_q)) ? sh_q : t[DimW-1:0];
  end
  logic fill_empty_q;
  logic [5:0] spr_q;
  logic [AW:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (ctl_i.clr_step) clr_q <= clr_q + 1'b1;
  end
  assign sts_o.clr_done = ctl_i.clr_step && (clr_q == (AW+1)'(Depth - 1));

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i; px_q <= px_i; py_q <= py_i; fg_q <= fg_i; color_q <= color_i;
      fx_q <= fx_i; fy_q <= fy_i; two_q <= two_i; lo_q <= lo_i; hi_q <= hi_i;
      onscr_q <= onscr;
      fx1_q <= x1c; fx2_q <= x2c; fy2_q <= y2c;
      fxc_q <= x1c; fyc_q <= y1c;
      fill_empty_q <= (x1c >= x2c) || (y1c >= y2c);
      spr_q <= '0;
    end else begin
      if (ctl_i.fill_step) begin
        if (fxc_q + 1'b1 >= fx2_q) begin
          fxc_q <= fx1_q; fyc_q <= fyc_q + 1'b1;
        end else fxc_q <= fxc_q + 1'b1;
      end
      if (ctl_i.spr_step) spr_q <= spr_q + 1'b1;
    end
  end
  assign sts_o.fill_empty = fill_empty_q;
  assign sts_o.fill_done = ctl_i.fill_step && (fxc_q + 1'b1 >= fx2_q)
                           && (fyc_q + 1'b1 >= fy2_q);
  assign sts_o.spr_done = ctl_i.spr_step && (spr_q == 6'd63);

  // sprite pixel
  logic [2:0] row, col;
  logic [7:0] bl, bh;
  logic [1:0] ch;
  logic [15:0] sx, sy;
  logic spr_we;
  assign row = spr_q[5:3];
  assign col = spr_q[2:0];
  assign bl = lo_q[{row, 3'b000} +: 8];
  assign bh = two_q ? hi_q[{row, 3'b000} +: 8] : 8'd0;
  assign ch = {bh[3'd7 - col], bl[3'd7 - col]};
  assign sy = py_q + 16'(fy_q ? 3'd7 - row : row);
  assign sx = px_q + 16'(fx_q ? 3'd7 - col : col);
  assign spr_we = ctl_i.spr_step && ((color_q != 4'd0 && color_q != 4'd5
                  && color_q != 4'd10 && color_q != 4'd15) || ch != 2'd0)
                  && ({1'b0, sx} < 17'(sw_q)) && ({1'b0, sy} < 17'(sh_q));

  // layer memory: two 2-bit planes, written per layer (both during the clearing pass)
  logic [1:0] bg_mem [Depth];
  logic [1:0] fgm_mem [Depth];
  logic we;
  logic wfg;
  logic [AW-1:0] waddr;
  logic [1:0] wdata;
  always_comb begin
    we = 1'b0; wfg = fg_q; waddr = '0; wdata = color_q[1:0];
    if (ctl_i.clr_step) begin
      we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
    end else if (ctl_i.fill_step) begin
      we = 1'b1; waddr = {fyc_q[YW-1:0], fxc_q[XW-1:0]};
    end else if (spr_we) begin
      we = 1'b1; waddr = {sy[YW-1:0], sx[XW-1:0]};
      wdata = blend(ch, color_q);
    end else if (ctl_i.res_load && cmd_q == CMD_PLOT && onscr_q) begin
      we = 1'b1; waddr = {py_q[YW-1:0], px_q[XW-1:0]};
    end
  end

  logic [1:0] rd_bg_q, rd_fg_q;
  logic [AW-1:0] raddr;
  assign raddr = {py_i[YW-1:0], px_i[XW-1:0]};
  always_ff @(posedge clk_i) begin
    if (we && (ctl_i.clr_step || !wfg)) bg_mem[waddr] <= wdata;
    if (ctl_i.rd_issue) rd_bg_q <= bg_mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (we && (ctl_i.clr_step || wfg)) fgm_mem[waddr] <= wdata;
    if (ctl_i.rd_issue) rd_fg_q <= fgm_mem[raddr];
  end

  logic [1:0] rd_col_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_capture) rd_col_q <= (rd_fg_q != 2'd0) ? rd_fg_q : rd_bg_q;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_o <= 1'b0;
    else if (ctl_i.res_load) res_valid_o <= 1'b1;
    else if (res_ready_i) res_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_color_o <= (cmd_q == CMD_READ && onscr_q) ? rd_col_q : 2'd0;
      res_ib_o <= (cmd_q == CMD_READ || cmd_q == CMD_PLOT) && onscr_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.res_load |=> res_valid_o) else $error("result not raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr_step |-> !ctl_i.load) else $error("load during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.clr_step, ctl_i.fill_step, ctl_i.spr_step}))
    else $error("write sources collide");
endmodule
`default_nettype wire

>>> rtl/tile_sprite_blitter.sv
// Result beat: plot goes from accept through ST_OUT, read through ST_RDWAIT and
// ST_OUT, sprite and fill through their walk and ST_OUT (an empty fill skips its walk).
// One command in flight: the next can be accepted in the cycle after the result beat
// leaves; walkers visit one pixel per cycle.
// Reset: a clearing pass walks all 65536 entries, one per cycle; no command
// is accepted during it. Screen size resets to 256x256.
// ----------------------------------------------------------------------------
// tile_sprite_blitter: two-layer 2bpp tile and sprite blitter
// Plot, fill, sprite draw and composed read on background/foreground layers.
// ----------------------------------------------------------------------------
`default_nettype none
module tile_sprite_blitter import tsb_pkg::*; (
  input  wire clk_i,
  input  wire rst_ni,
  input  wire cfg_we_i,
  input  wire [CfgIdxW-1:0] cfg_idx_i,
  input  wire [DimW-1:0] cfg_data_i,
  tsb_cmd_if.sink cmd_i,
  tsb_res_if.source res_o
);
  ctl_t ctl;
  sts_t sts;
  logic ready;

  // controller: one command in flight; waits while a result beat is held
  tsb_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(cmd_i.valid),
    .cmd_i(cmd_e'(cmd_i.command)), .res_busy_i(res_o.valid),
    .sts_i(sts), .in_ready_o(ready), .ctl_o(ctl)
  );
  assign cmd_i.ready = ready;

  tsb_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl), .sts_o(sts),
    .cmd_i(cmd_i.command), .px_i(cmd_i.pos_x), .py_i(cmd_i.pos_y),
    .fg_i(cmd_i.layer_select), .color_i(cmd_i.color_code), .fx_i(cmd_i.flip_x),
    .fy_i(cmd_i.flip_y), .two_i(cmd_i.two_bits), .lo_i(cmd_i.plane_low),
    .hi_i(cmd_i.plane_high), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .res_ready_i(res_o.ready),
    .res_valid_o(res_o.valid), .res_color_o(res_o.read_color),
    .res_ib_o(res_o.in_bounds)
  );
endmodule
`default_nettype wire
